### hw/rtl/wbls_pkg.sv
package wbls_pkg;

  localparam int unsigned VAL_W     = 16;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned DECAY_W   = 17;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned NUM_REGS  = 4;
  localparam int unsigned PROD_W    = 32;
  localparam int unsigned NUM_W     = 48;
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned DIV_CNT_W = 4;
  localparam int unsigned IN_DATA_W = 48;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [DECAY_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [OP_W-1:0] OP_ADD_LEFT  = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_RIGHT = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD_DOWN  = 3'd2;
  localparam logic [OP_W-1:0] OP_ADD_UP    = 3'd3;
  localparam logic [OP_W-1:0] OP_READ      = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd5;

  typedef struct packed {
    logic load;
    logic rd;
    logic clr_start;
    logic clr_step;
    logic stage_a;
    logic stage_b;
    logic stage_c;
    logic div_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_valid;
    logic arith;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/weighted_bidirectional_line_smoother.sv
// Quality-weighted smoother for one line, with a forward and a backward pass.
// Words enter on the s_axis side; the operation code rides in tuser (add left,
// add right, add down, add up, read, clear). An add whose weight is below its
// pass accumulator is blended toward it with its operation's decay register,
// stored, copied into the accumulator and returned; a read returns the
// weight-averaged value of both passes and their mean weight. Clear,
// undefined codes and positions beyond the line return nothing.
// An add that needs no blend goes from decode straight to the output register; a
// blended add or a read passes through the two multiply stages and then the
// 16-step restoring divider; a clear runs a clearing pass that writes one entry
// per cycle. The same clearing pass runs after reset, during which no word is
// accepted. A finished result waits in an output register while the next word
// is taken. Decay registers are written through the cfg channel; the user must
// write them only while no word is in flight, which the block does not enforce.
module weighted_bidirectional_line_smoother #(
  parameter int unsigned LINE_LENGTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // position[9:0], sample_value[25:10], sample_weight[41:26], zero fill
  input  logic [wbls_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // operation[2:0]
  input  logic [wbls_pkg::OP_W-1:0]           s_axis_tuser_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // smoothed_value[15:0], smoothed_weight[31:16]
  output logic [wbls_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wbls_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [wbls_pkg::DECAY_W-1:0]        cfg_data_i
);
  import wbls_pkg::*;

  localparam int unsigned AW = $clog2(LINE_LENGTH);

  cmd_t                 cmd;
  sts_t                 sts;
  logic                 fwd_we, bwd_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [2*VAL_W-1:0]   mem_wdata, fwd_rdata, bwd_rdata;

  assign cfg_ready_o = 1'b1;

  wbls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wbls_dpath #(
    .LINE_LENGTH (LINE_LENGTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .m_tready_i  (m_axis_tready_i),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tdata_o   (m_axis_tdata_o),
    .fwd_we_o    (fwd_we),
    .bwd_we_o    (bwd_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .fwd_rdata_i (fwd_rdata),
    .bwd_rdata_i (bwd_rdata)
  );

  // value in the upper half, weight in the lower half
  wbls_ram #(
    .WIDTH (2*VAL_W),
    .DEPTH (LINE_LENGTH)
  ) u_fwd_ram (
    .clk_i   (clk_i),
    .we_i    (fwd_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (fwd_rdata)
  );

  wbls_ram #(
    .WIDTH (2*VAL_W),
    .DEPTH (LINE_LENGTH)
  ) u_bwd_ram (
    .clk_i   (clk_i),
    .we_i    (bwd_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (bwd_rdata)
  );

endmodule

### hw/rtl/wbls_ram.sv
module wbls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/wbls_ctrl.sv
module wbls_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  input  wbls_pkg::sts_t sts_i,
  output wbls_pkg::cmd_t cmd_o
);
  import wbls_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_MA   = 3'd3;
  localparam logic [2:0] S_MB   = 3'd4;
  localparam logic [2:0] S_SUM  = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]           state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        if (sts_i.is_clear) begin
          cmd_o.clr_start = 1'b1;
          state_d         = S_CLR;
        end else if (!sts_i.is_valid) begin
          state_d = S_IDLE;
        end else if (sts_i.arith) begin
          cmd_o.rd = 1'b1;
          state_d  = S_MA;
        end else begin
          state_d = S_FIN;
        end
      end
      S_MA: begin
        cmd_o.stage_a = 1'b1;
        state_d       = S_MB;
      end
      S_MB: begin
        cmd_o.stage_b = 1'b1;
        state_d       = S_SUM;
      end
      S_SUM: begin
        cmd_o.stage_c = 1'b1;
        cnt_d         = '0;
        state_d       = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### hw/rtl/wbls_dpath.sv
module wbls_dpath #(
  parameter int unsigned LINE_LENGTH = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  wbls_pkg::cmd_t                       cmd_i,
  output wbls_pkg::sts_t                       sts_o,
  input  logic [wbls_pkg::IN_DATA_W-1:0]       s_tdata_i,
  input  logic [wbls_pkg::OP_W-1:0]            s_tuser_i,
  input  logic                                 cfg_valid_i,
  input  logic [wbls_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [wbls_pkg::DECAY_W-1:0]         cfg_data_i,
  input  logic                                 m_tready_i,
  output logic                                 m_tvalid_o,
  output logic [wbls_pkg::OUT_DATA_W-1:0]      m_tdata_o,
  output logic                                 fwd_we_o,
  output logic                                 bwd_we_o,
  output logic [$clog2(LINE_LENGTH)-1:0]       mem_waddr_o,
  output logic [2*wbls_pkg::VAL_W-1:0]         mem_wdata_o,
  output logic                                 mem_re_o,
  output logic [$clog2(LINE_LENGTH)-1:0]       mem_raddr_o,
  input  logic [2*wbls_pkg::VAL_W-1:0]         fwd_rdata_i,
  input  logic [2*wbls_pkg::VAL_W-1:0]         bwd_rdata_i
);
  import wbls_pkg::*;

  localparam int unsigned AW = $clog2(LINE_LENGTH);

  logic [OP_W-1:0]    op_q;
  logic [POS_W-1:0]   pos_q;
  logic [VAL_W-1:0]   sv_q, sw_q;
  logic [DECAY_W-1:0] decay_q [NUM_REGS];
  logic [VAL_W-1:0]   facc_v_q, facc_w_q, bacc_v_q, bacc_w_q;
  logic [PROD_W-1:0]  x_q, x_d, y_q, y_d, den_q, den_d;
  logic [VAL_W-1:0]   b1_q, b1_d, b2_q, b2_d, wres_q, wres_d;
  logic [NUM_W-1:0]   p1_q, p2_q;
  logic [PROD_W-1:0]  rem_q, rem_d;
  logic [VAL_W-1:0]   quo_q, quo_d;
  logic [AW-1:0]      clr_addr_q, clr_addr_d;
  logic               out_valid_q;
  logic [VAL_W-1:0]   out_val_q, out_wgt_q;

  logic               is_fwd, is_read, is_add, pos_ok, arith;
  logic [VAL_W-1:0]   acc_v, acc_w, res_val, res_wgt;
  logic [DECAY_W-1:0] d_raw, d_sat, d_inv;
  logic [32:0]        mw1, mw2, sum_w, rnd_w;
  logic [NUM_W-1:0]   num;
  logic [32:0]        div_t, div_diff;
  logic               div_ge;
  logic               clr_last;

  // decode of the held word
  assign is_fwd  = (op_q == OP_ADD_LEFT) || (op_q == OP_ADD_DOWN);
  assign is_read = (op_q == OP_READ);
  assign is_add  = (op_q == OP_ADD_LEFT) || (op_q == OP_ADD_RIGHT) ||
                   (op_q == OP_ADD_DOWN) || (op_q == OP_ADD_UP);
  assign pos_ok  = (32'(pos_q) < LINE_LENGTH);
  assign acc_v   = is_fwd ? facc_v_q : bacc_v_q;
  assign acc_w   = is_fwd ? facc_w_q : bacc_w_q;
  assign arith   = is_read || (sw_q < acc_w);

  assign d_raw = decay_q[op_q[1:0]];
  assign d_sat = (d_raw > ONE_Q16) ? ONE_Q16 : d_raw;
  assign d_inv = ONE_Q16 - d_sat;

  assign clr_last = (clr_addr_q == AW'(LINE_LENGTH - 1));

  assign sts_o.is_clear = (op_q == OP_CLEAR);
  assign sts_o.is_valid = (is_add || is_read) && pos_ok;
  assign sts_o.arith    = arith;
  assign sts_o.clr_last = clr_last;
  assign sts_o.out_free = !out_valid_q || m_tready_i;

  // weights and multiplicands
  always_comb begin
    mw1 = 33'(d_inv) * 33'(sw_q);
    mw2 = 33'(d_sat) * 33'(acc_w);
    x_d  = x_q;
    y_d  = y_q;
    b1_d = b1_q;
    b2_d = b2_q;
    if (cmd_i.stage_a) begin
      if (is_read) begin
        x_d  = PROD_W'(fwd_rdata_i[VAL_W-1:0]);
        y_d  = PROD_W'(bwd_rdata_i[VAL_W-1:0]);
        b1_d = fwd_rdata_i[2*VAL_W-1:VAL_W];
        b2_d = bwd_rdata_i[2*VAL_W-1:VAL_W];
      end else begin
        x_d  = mw1[PROD_W-1:0];
        y_d  = mw2[PROD_W-1:0];
        b1_d = sv_q;
        b2_d = acc_v;
      end
    end
  end

  // divisor and result weight
  always_comb begin
    sum_w  = {1'b0, x_q} + {1'b0, y_q};
    rnd_w  = sum_w + 33'd32768;
    den_d  = den_q;
    wres_d = wres_q;
    if (cmd_i.stage_b) begin
      den_d  = sum_w[PROD_W-1:0];
      wres_d = is_read ? sum_w[VAL_W:1] : rnd_w[PROD_W-1:VAL_W];
    end
  end

  // restoring divider, one quotient bit per step
  always_comb begin
    num      = p1_q + p2_q + NUM_W'(den_q[PROD_W-1:1]);
    div_t    = {rem_q, quo_q[VAL_W-1]};
    div_diff = div_t - {1'b0, den_q};
    div_ge   = (div_t >= {1'b0, den_q});
    rem_d    = rem_q;
    quo_d    = quo_q;
    if (cmd_i.stage_c) begin
      rem_d = num[NUM_W-1:VAL_W];
      quo_d = num[VAL_W-1:0];
    end else if (cmd_i.div_step) begin
      rem_d = div_ge ? div_diff[PROD_W-1:0] : div_t[PROD_W-1:0];
      quo_d = {quo_q[VAL_W-2:0], div_ge};
    end
  end

  always_comb begin
    if (!arith) begin
      res_val = sv_q;
      res_wgt = sw_q;
    end else begin
      res_wgt = wres_q;
      if (den_q == '0) begin
        res_val = is_read ? '0 : sv_q;
      end else begin
        res_val = quo_q;
      end
    end
  end

  always_comb begin
    clr_addr_d = clr_addr_q;
    if (cmd_i.clr_step) begin
      clr_addr_d = clr_last ? '0 : clr_addr_q + 1'b1;
    end
  end

  assign fwd_we_o    = cmd_i.clr_step || (cmd_i.commit && is_add && is_fwd);
  assign bwd_we_o    = cmd_i.clr_step || (cmd_i.commit && is_add && !is_fwd);
  assign mem_waddr_o = cmd_i.clr_step ? clr_addr_q : AW'(pos_q);
  assign mem_wdata_o = cmd_i.clr_step ? '0 : {res_val, res_wgt};
  assign mem_re_o    = cmd_i.rd;
  assign mem_raddr_o = AW'(pos_q);

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {out_wgt_q, out_val_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= s_tuser_i;
      pos_q <= s_tdata_i[POS_W-1:0];
      sv_q  <= s_tdata_i[POS_W+VAL_W-1:POS_W];
      sw_q  <= s_tdata_i[POS_W+2*VAL_W-1:POS_W+VAL_W];
    end
    if (cmd_i.stage_b) begin
      p1_q <= NUM_W'(x_q) * NUM_W'(b1_q);
      p2_q <= NUM_W'(y_q) * NUM_W'(b2_q);
    end
    if (cmd_i.commit) begin
      out_val_q <= res_val;
      out_wgt_q <= res_wgt;
    end
    x_q    <= x_d;
    y_q    <= y_d;
    b1_q   <= b1_d;
    b2_q   <= b2_d;
    den_q  <= den_d;
    wres_q <= wres_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        decay_q[i] <= '0;
      end
      facc_v_q    <= '0;
      facc_w_q    <= '0;
      bacc_v_q    <= '0;
      bacc_w_q    <= '0;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && (32'(cfg_index_i) < NUM_REGS)) begin
        decay_q[cfg_index_i[1:0]] <= cfg_data_i;
      end
      if (cmd_i.clr_start) begin
        facc_v_q <= '0;
        facc_w_q <= '0;
        bacc_v_q <= '0;
        bacc_w_q <= '0;
      end else if (cmd_i.commit && is_add) begin
        if (is_fwd) begin
          facc_v_q <= res_val;
          facc_w_q <= res_wgt;
        end else begin
          bacc_v_q <= res_val;
          bacc_w_q <= res_wgt;
        end
      end
      clr_addr_q <= clr_addr_d;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

### verif/weighted_bidirectional_line_smoother_tb.sv
`timescale 1ns / 1ps

module weighted_bidirectional_line_smoother_tb;
  import wbls_pkg::*;

  localparam int unsigned LINE_LEN      = 1024;
  localparam int unsigned STALL_LIMIT   = 8000;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned SETTLE_CYCLES = LINE_LEN + 40;
  localparam int unsigned MAX_REPORTS   = 10;

  localparam logic [CFG_IDX_W-1:0] REG_DECAY_H_FWD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_H_BWD = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_V_FWD = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_V_BWD = 8'd3;

  localparam logic [OP_W-1:0] OP_UNDEF_A = 3'd6;
  localparam logic [OP_W-1:0] OP_UNDEF_B = 3'd7;

  typedef struct packed {
    logic [VAL_W-1:0] weight;
    logic [VAL_W-1:0] value;
  } smoothed_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic [OP_W-1:0]       s_axis_tuser_i  = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i     = '0;
  logic [DECAY_W-1:0]    cfg_data_i      = '0;

  logic [DECAY_W-1:0] decay_q [NUM_REGS];
  logic [VAL_W-1:0]   fwd_val [LINE_LEN];
  logic [VAL_W-1:0]   fwd_wgt [LINE_LEN];
  logic [VAL_W-1:0]   bwd_val [LINE_LEN];
  logic [VAL_W-1:0]   bwd_wgt [LINE_LEN];
  logic [VAL_W-1:0]   fwd_acc_val, fwd_acc_wgt, bwd_acc_val, bwd_acc_wgt;
  smoothed_t          smoothed_q [$];

  bit          tx_idle_on   = 1'b1;
  bit          rx_idle_on   = 1'b1;
  bit          hold_req     = 1'b0;
  int unsigned words_sent   = 0;
  int unsigned clears_sent  = 0;
  int unsigned results_seen = 0;
  int unsigned phases_run   = 0;
  int unsigned fail_cnt     = 0;

  weighted_bidirectional_line_smoother #(
    .LINE_LENGTH(LINE_LEN)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic clear_line();
    for (int i = 0; i < LINE_LEN; i++) begin
      fwd_val[i] = '0;
      fwd_wgt[i] = '0;
      bwd_val[i] = '0;
      bwd_wgt[i] = '0;
    end
    fwd_acc_val = '0;
    fwd_acc_wgt = '0;
    bwd_acc_val = '0;
    bwd_acc_wgt = '0;
  endtask

  // accumulator ends up holding the entry that gets stored
  task automatic blend_pass(input logic [DECAY_W-1:0] decay, input logic [VAL_W-1:0] sv,
                            input logic [VAL_W-1:0] sw, inout logic [VAL_W-1:0] acc_val,
                            inout logic [VAL_W-1:0] acc_wgt);
    logic [DECAY_W-1:0] d;
    longint unsigned    w1, w2, wsum, num, q, nw;
    d = (decay > ONE_Q16) ? ONE_Q16 : decay;
    if (sw < acc_wgt) begin
      w1   = 64'(ONE_Q16 - d) * 64'(sw);
      w2   = 64'(d) * 64'(acc_wgt);
      wsum = w1 + w2;
      nw   = (wsum + 64'd32768) >> 16;
      if (nw > 64'd65535) nw = 64'd65535;
      q = 64'(sv);
      if (wsum != 0) begin
        num = w1 * 64'(sv) + w2 * 64'(acc_val);
        q   = (num + (wsum >> 1)) / wsum;
        if (q > 64'd65535) q = 64'd65535;
      end
      acc_val = q[VAL_W-1:0];
      acc_wgt = nw[VAL_W-1:0];
    end else begin
      acc_val = sv;
      acc_wgt = sw;
    end
  endtask

  task automatic smooth_predict(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] sv, input logic [VAL_W-1:0] sw);
    smoothed_t       res;
    logic [VAL_W:0]  wsum;
    longint unsigned num, q;
    case (op)
      OP_ADD_LEFT, OP_ADD_DOWN: begin
        blend_pass(decay_q[op[1:0]], sv, sw, fwd_acc_val, fwd_acc_wgt);
        fwd_val[pos] = fwd_acc_val;
        fwd_wgt[pos] = fwd_acc_wgt;
        res.value    = fwd_acc_val;
        res.weight   = fwd_acc_wgt;
        smoothed_q.push_back(res);
      end
      OP_ADD_RIGHT, OP_ADD_UP: begin
        blend_pass(decay_q[op[1:0]], sv, sw, bwd_acc_val, bwd_acc_wgt);
        bwd_val[pos] = bwd_acc_val;
        bwd_wgt[pos] = bwd_acc_wgt;
        res.value    = bwd_acc_val;
        res.weight   = bwd_acc_wgt;
        smoothed_q.push_back(res);
      end
      OP_READ: begin
        wsum = {1'b0, fwd_wgt[pos]} + {1'b0, bwd_wgt[pos]};
        q    = 0;
        if (wsum != 0) begin
          num = 64'(fwd_wgt[pos]) * 64'(fwd_val[pos]) + 64'(bwd_wgt[pos]) * 64'(bwd_val[pos]);
          q   = (num + 64'(wsum >> 1)) / 64'(wsum);
          if (q > 64'd65535) q = 64'd65535;
        end
        res.value  = q[VAL_W-1:0];
        res.weight = wsum[VAL_W:1];
        smoothed_q.push_back(res);
      end
      OP_CLEAR: clear_line();
      default: ;
    endcase
  endtask

  function automatic logic [VAL_W-1:0] rand_weight();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return VAL_W'($urandom_range(1, 16'h0400));
      2:       return VAL_W'($urandom_range(16'hF000, 16'hFFFF));
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // returns at the accepting edge with tvalid still high; the caller sends the
  // next word or settles in the same step
  task automatic send_word(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] sv, input logic [VAL_W-1:0] sw);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata_i  <= {{(IN_DATA_W - POS_W - 2 * VAL_W){1'b0}}, sw, sv, pos};
    s_axis_tuser_i  <= op;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    smooth_predict(op, pos, sv, sw);
    if (op <= OP_CLEAR) words_sent++;
    if (op == OP_CLEAR) clears_sent++;
  endtask

  // a clear leaves no result behind, so also wait out a full clearing pass
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (smoothed_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [DECAY_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < NUM_REGS) decay_q[idx[1:0]] = data;
  endtask

  task automatic program_decays(input logic [DECAY_W-1:0] h_fwd, input logic [DECAY_W-1:0] h_bwd,
                                input logic [DECAY_W-1:0] v_fwd, input logic [DECAY_W-1:0] v_bwd);
    write_cfg(REG_DECAY_H_FWD, h_fwd);
    write_cfg(REG_DECAY_H_BWD, h_bwd);
    write_cfg(REG_DECAY_V_FWD, v_fwd);
    write_cfg(REG_DECAY_V_BWD, v_bwd);
    // out of range index must not disturb the decays
    write_cfg(CFG_IDX_W'($urandom_range(NUM_REGS, 255)), DECAY_W'($urandom));
    cfg_valid_i <= 1'b0;
    phases_run++;
  endtask

  task automatic test_directed();
    program_decays(17'd16384, 17'd49152, 17'd0, 17'h1FFFF);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_word(OP_ADD_LEFT, 10'd0, 16'hFFFF, 16'hFFFF);
    send_word(OP_ADD_LEFT, 10'd1023, 16'h0000, 16'h0000);
    send_word(OP_ADD_LEFT, 10'd1, 16'd1234, 16'h8000);
    // zero blended weight keeps the sample value
    send_word(OP_ADD_DOWN, 10'd2, 16'hFFFF, 16'h0000);
    send_word(OP_ADD_RIGHT, 10'd1023, 16'hFFFF, 16'hFFFF);
    send_word(OP_ADD_RIGHT, 10'd0, 16'h0000, 16'h0001);
    // decay above one saturates
    send_word(OP_ADD_UP, 10'd512, 16'h5555, 16'h0000);
    send_word(OP_ADD_UP, 10'd513, 16'hAAAA, 16'hFFFF);
    send_word(OP_READ, 10'd0, 16'hFFFF, 16'hFFFF);
    send_word(OP_READ, 10'd1023, 16'h0000, 16'h0000);
    send_word(OP_READ, 10'd700, 16'h0000, 16'h0000);
    send_word(OP_READ, 10'd2, 16'h0000, 16'h0000);
    send_word(OP_UNDEF_A, 10'd3, 16'h1234, 16'h4321);
    send_word(OP_UNDEF_B, 10'd1022, 16'hFFFF, 16'hFFFF);
    send_word(OP_CLEAR, 10'd0, 16'h0000, 16'h0000);
    send_word(OP_READ, 10'd0, 16'h0000, 16'h0000);
    send_word(OP_ADD_LEFT, 10'd0, 16'd100, 16'd50);
    // equal weight is stored unblended
    send_word(OP_ADD_LEFT, 10'd3, 16'd7, 16'd50);
    send_word(OP_READ, 10'd3, 16'h0000, 16'h0000);
    settle();
  endtask

  task automatic test_random_phase(input logic [DECAY_W-1:0] h_fwd,
                                   input logic [DECAY_W-1:0] h_bwd,
                                   input logic [DECAY_W-1:0] v_fwd,
                                   input logic [DECAY_W-1:0] v_bwd,
                                   input int unsigned n_words);
    int unsigned      target, kind, len;
    logic [POS_W-1:0] base;
    logic [OP_W-1:0]  fwd_op, bwd_op;
    program_decays(h_fwd, h_bwd, v_fwd, v_bwd);
    target = words_sent + n_words;
    base   = POS_W'($urandom);
    while (words_sent < target) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      kind       = $urandom_range(0, 99);
      if (kind < 60) begin
        // forward sweep, backward sweep over the same span, then reads
        fwd_op = $urandom_range(0, 1) ? OP_ADD_LEFT : OP_ADD_DOWN;
        bwd_op = $urandom_range(0, 1) ? OP_ADD_RIGHT : OP_ADD_UP;
        len    = $urandom_range(4, 16);
        base   = POS_W'($urandom);
        for (int i = 0; i < len; i++)
          send_word(fwd_op, POS_W'(base + i), VAL_W'($urandom), rand_weight());
        for (int i = len - 1; i >= 0; i--)
          send_word(bwd_op, POS_W'(base + i), VAL_W'($urandom), rand_weight());
        for (int i = 0; i < len; i += 2)
          send_word(OP_READ, POS_W'(base + i), VAL_W'($urandom), VAL_W'($urandom));
      end else if (kind < 85) begin
        send_word(OP_W'($urandom_range(OP_ADD_LEFT, OP_READ)), POS_W'($urandom),
                  VAL_W'($urandom), rand_weight());
      end else if (kind < 95) begin
        send_word(OP_READ, base + POS_W'($urandom_range(0, 31)), VAL_W'($urandom),
                  VAL_W'($urandom));
      end else if (kind < 98) begin
        send_word(OP_W'($urandom_range(OP_UNDEF_A, OP_UNDEF_B)), POS_W'($urandom),
                  VAL_W'($urandom), VAL_W'($urandom));
      end else begin
        send_word(OP_CLEAR, POS_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
      end
    end
    settle();
  endtask

  task automatic test_output_stall();
    logic [POS_W-1:0] base;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    base       = POS_W'($urandom);
    hold_req   = 1'b1;
    for (int i = 0; i < 40; i++)
      send_word((i % 2 != 0) ? OP_READ : OP_ADD_LEFT, POS_W'(base + i / 2), VAL_W'($urandom),
                rand_weight());
    settle();
  endtask

  initial begin : result_sink
    int unsigned stall_left, hold_left;
    smoothed_t   got, want;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = m_axis_tdata_o;
        results_seen++;
        if (smoothed_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("unexpected word: value %h weight %h", got.value, got.weight);
        end else begin
          want = smoothed_q.pop_front();
          if (got.value !== want.value || got.weight !== want.weight) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
              $display("result %0d: expected value %h weight %h, got value %h weight %h",
                       results_seen, want.value, want.weight, got.value, got.weight);
          end
        end
        stall_left = rx_idle_on ? $urandom_range(0, 19) : 0;
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      m_axis_tready_i <= rst_ni && stall_left == 0 && hold_left == 0;
      if (stall_left != 0) stall_left--;
      if (hold_left != 0) hold_left--;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    do begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end while (quiet < STALL_LIMIT);
    $display("no word moved for %0d cycles, %0d results still pending", STALL_LIMIT,
             smoothed_q.size());
    $display("Verification failed");
    $finish;
  end

  initial begin : test_sequence
    decay_q = '{default: '0};
    clear_line();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_phase(17'd0, 17'd0, 17'd0, 17'd0, 200);
    test_random_phase(ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16, 200);
    test_random_phase(17'h1FFFF, 17'd65535, 17'd1, 17'd32768, 200);
    test_random_phase(DECAY_W'($urandom), DECAY_W'($urandom), DECAY_W'($urandom),
                      DECAY_W'($urandom), 200);
    test_random_phase(DECAY_W'($urandom_range(0, 65536)), DECAY_W'($urandom_range(0, 65536)),
                      DECAY_W'($urandom_range(0, 65536)), DECAY_W'($urandom_range(0, 65536)),
                      200);
    test_output_stall();
    if (smoothed_q.size() != 0) fail_cnt++;
    $display("sent %0d words (%0d clears) under %0d decay settings plus an output hold-off",
             words_sent, clears_sent, phases_run);
    $display("checked %0d results, %0d failures", results_seen, fail_cnt);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
